FILE: rtl/core/subsurface_darcy_edge_flux_assert.svh
// assertion macros for the edge flux block
`ifndef SUBSURFACE_DARCY_EDGE_FLUX_ASSERT_SVH
`define SUBSURFACE_DARCY_EDGE_FLUX_ASSERT_SVH

// same-cycle implication
`define SDEF_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SDEF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/sdef_pkg.sv
`timescale 1ns / 1ps
package sdef_pkg;

  localparam int FRAC_BITS  = 40;
  localparam int WORD_W     = 64;
  localparam int LEN_W      = 63;
  localparam int FRAC_REG_W = 41;
  localparam int KIND_W     = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int PROD_W     = 2 * WORD_W;
  localparam int HALF_W     = WORD_W / 2;
  localparam int DIV_STEPS  = WORD_W;
  localparam int TDATA_W    = 448;

  localparam int MUL_LAT = 4;
  localparam int DIV_LAT = DIV_STEPS + 3;

  // pipeline stage numbers of the top level
  localparam int ST_LATE_FIRST = 3;
  localparam int ST_K1D1_IN    = 6;
  localparam int ST_NUM        = 11;
  localparam int ST_MID_LAST   = ST_NUM - 1;
  localparam int ST_Q_OUT      = 2 + DIV_LAT;
  localparam int ST_EFF_OUT    = ST_NUM + DIV_LAT;
  localparam int ST_EFF        = ST_EFF_OUT + 1;
  localparam int ST_K          = ST_EFF + 1;
  localparam int ST_KQ_OUT     = ST_K + MUL_LAT;
  localparam int ST_H_OUT      = ST_KQ_OUT + MUL_LAT;
  localparam int ST_E_OUT      = ST_H_OUT + MUL_LAT;
  localparam int ST_OUT        = ST_E_OUT + 1;

  typedef logic signed [WORD_W-1:0] word_t;

  localparam word_t S_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t S_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam word_t Q_ONE = word_t'(1) << FRAC_BITS;

  localparam logic [LEN_W-1:0] SOIL_DEPTH_RST  = LEN_W'(2) << FRAC_BITS;
  localparam logic [LEN_W-1:0] MACRO_DEPTH_RST = LEN_W'(1) << FRAC_BITS;

  typedef enum logic [KIND_W-1:0] {
    KIND_NABR   = 2'd0,
    KIND_NOFLOW = 2'd1,
    KIND_HEAD   = 2'd2,
    KIND_FLUX   = 2'd3
  } kind_t;

  localparam logic [CFG_ADDR_W-1:0] REG_SOIL_DEPTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MACRO_DEPTH = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MACRO_K     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MACRO_FRAC  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MATRIX_K    = 3'd4;

  function automatic word_t sat_add(word_t a, word_t b);
    logic signed [WORD_W:0] s;
    s = (WORD_W+1)'(a) + (WORD_W+1)'(b);
    if (s[WORD_W] != s[WORD_W-1]) return s[WORD_W] ? S_MIN : S_MAX;
    return s[WORD_W-1:0];
  endfunction

  function automatic word_t sat_sub(word_t a, word_t b);
    logic signed [WORD_W:0] s;
    s = (WORD_W+1)'(a) - (WORD_W+1)'(b);
    if (s[WORD_W] != s[WORD_W-1]) return s[WORD_W] ? S_MIN : S_MAX;
    return s[WORD_W-1:0];
  endfunction

  function automatic word_t pos(word_t a);
    return a[WORD_W-1] ? word_t'(0) : a;
  endfunction

  function automatic word_t from_mag(logic [WORD_W-1:0] m, logic neg, logic ovf);
    if (neg) begin
      if (ovf || m[WORD_W-1]) return S_MIN;
      return word_t'(~m + WORD_W'(1));
    end
    if (ovf || m[WORD_W-1]) return S_MAX;
    return word_t'(m);
  endfunction

  function automatic word_t mean_floor(word_t a, word_t b);
    logic signed [WORD_W:0] s;
    s = (WORD_W+1)'(a) + (WORD_W+1)'(b);
    return s[WORD_W:1];
  endfunction

endpackage

FILE: rtl/core/subsurface_darcy_edge_flux.sv
`timescale 1ns / 1ps
// throughput: one edge per cycle while the output is not stalled, set by the fully pipelined dividers
// (one quotient bit per stage) and the four-stage multipliers
// the whole pipeline holds while the output word waits
// reset: synchronous, clears valid bits and loads register defaults
`include "subsurface_darcy_edge_flux_assert.svh"
module subsurface_darcy_edge_flux (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sdef_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [sdef_pkg::LEN_W-1:0]       cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // gw_self, z_self, gw_nabr, z_nabr, distance, edge_length, bc_value, zero pad
  input  logic [sdef_pkg::TDATA_W-1:0]     s_tdata,
  // edge_kind
  input  logic [sdef_pkg::KIND_W-1:0]      s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // flux
  output logic [sdef_pkg::WORD_W-1:0]      m_tdata
);
  import sdef_pkg::*;

  typedef struct packed {
    kind_t             kind;
    logic              les;
    logic              len;
    word_t             h;
    logic [LEN_W-1:0]  edge_len;
    word_t             negbc;
  } late_t;

  typedef struct packed {
    word_t d1s;
    word_t d1n;
    word_t dens;
    word_t denn;
  } mid_t;

  logic [LEN_W-1:0]      soil_depth, macropore_depth, macropore_k, matrix_k;
  logic [FRAC_REG_W-1:0] macropore_area_frac;
  word_t sd_w, dm_w, mk_w, ks_w, fr_w;
  word_t top_depth, one_m_frac, k1, k1a, k1b, ks_top;

  logic              adv;
  logic [ST_OUT:1]   vld;

  word_t in_gws, in_zs, in_gwn, in_zn, in_bc;

  kind_t            s1_kind;
  word_t            s1_ss, s1_sn, s1_gs, s1_gn, s1_hb, s1_bc, s1_negbc;
  logic [LEN_W-1:0] s1_edge, s1_dist;

  kind_t            s2_kind;
  word_t            s2_diff, s2_gs, s2_gn, s2_hb, s2_negbc, s2_d1s, s2_d1n;
  logic [LEN_W-1:0] s2_edge, s2_dist;
  logic             s2_les, s2_len;

  late_t late [ST_LATE_FIRST:ST_E_OUT];
  mid_t  mid  [ST_LATE_FIRST:ST_MID_LAST];

  word_t p_s, p_n, s11_nums, s11_numn, s11_dens, s11_denn;
  word_t q_s, q_n, q_g, s79_effs, s79_effn, s80_k;
  word_t qd [ST_Q_OUT+1:ST_K];
  word_t m1, m2, m3, out_flux;

  assign sd_w = word_t'(soil_depth);
  assign dm_w = word_t'(macropore_depth);
  assign mk_w = word_t'(macropore_k);
  assign ks_w = word_t'(matrix_k);
  assign fr_w = word_t'(macropore_area_frac);

  assign in_gws = s_tdata[63:0];
  assign in_zs  = s_tdata[127:64];
  assign in_gwn = s_tdata[191:128];
  assign in_zn  = s_tdata[255:192];
  assign in_bc  = s_tdata[445:382];

  assign adv      = !vld[ST_OUT] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[ST_OUT];
  assign m_tdata  = out_flux;

  always_ff @(posedge clk) begin
    if (rst) begin
      soil_depth          <= SOIL_DEPTH_RST;
      macropore_depth     <= MACRO_DEPTH_RST;
      macropore_k         <= '0;
      macropore_area_frac <= '0;
      matrix_k            <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SOIL_DEPTH:  soil_depth <= cfg_data;
        REG_MACRO_DEPTH: macropore_depth <= cfg_data;
        REG_MACRO_K:     macropore_k <= cfg_data;
        REG_MACRO_FRAC:  macropore_area_frac <= cfg_data[FRAC_REG_W-1:0];
        REG_MATRIX_K:    matrix_k <= cfg_data;
        default: ;
      endcase
    end
  end

  // soil terms that depend on the registers only
  always_ff @(posedge clk) begin
    top_depth  <= sd_w - dm_w;
    one_m_frac <= Q_ONE - fr_w;
    k1         <= sat_add(k1a, k1b);
  end

  sdef_mul u_mul_k1a (.clk(clk), .en(1'b1), .a(mk_w), .b(fr_w), .q(k1a));
  sdef_mul u_mul_k1b (.clk(clk), .en(1'b1), .a(ks_w), .b(one_m_frac), .q(k1b));
  sdef_mul u_mul_kst (.clk(clk), .en(1'b1), .a(ks_w), .b(top_depth), .q(ks_top));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[ST_OUT-1:1], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind  <= kind_t'(s_tuser);
      s1_ss    <= sat_add(in_gws, in_zs);
      s1_sn    <= sat_add(in_gwn, in_zn);
      s1_gs    <= pos(in_gws);
      s1_gn    <= pos(in_gwn);
      s1_hb    <= pos(sat_sub(in_bc, in_zs));
      s1_bc    <= in_bc;
      s1_negbc <= (in_bc == S_MIN) ? S_MAX : -in_bc;
      s1_dist  <= s_tdata[318:256];
      s1_edge  <= s_tdata[381:319];

      s2_kind  <= s1_kind;
      s2_diff  <= sat_sub(s1_ss, (s1_kind == KIND_NABR) ? s1_sn : s1_bc);
      s2_gs    <= s1_gs;
      s2_gn    <= s1_gn;
      s2_hb    <= s1_hb;
      s2_negbc <= s1_negbc;
      s2_edge  <= s1_edge;
      s2_dist  <= s1_dist;
      s2_les   <= (s1_gs <= top_depth);
      s2_len   <= (s1_gn <= top_depth);
      s2_d1s   <= (s1_gs > sd_w) ? dm_w : sat_sub(s1_gs, top_depth);
      s2_d1n   <= (s1_gn > sd_w) ? dm_w : sat_sub(s1_gn, top_depth);

      late[ST_LATE_FIRST].kind     <= s2_kind;
      late[ST_LATE_FIRST].les      <= s2_les;
      late[ST_LATE_FIRST].len      <= s2_len;
      late[ST_LATE_FIRST].h        <= (!s2_diff[WORD_W-1] && (s2_diff != '0)) ? s2_gs
                                    : ((s2_kind == KIND_NABR) ? s2_gn : s2_hb);
      late[ST_LATE_FIRST].edge_len <= s2_edge;
      late[ST_LATE_FIRST].negbc    <= s2_negbc;
      for (int i = ST_LATE_FIRST + 1; i <= ST_E_OUT; i++) begin
        late[i] <= late[i-1];
      end

      mid[ST_LATE_FIRST].d1s  <= s2_d1s;
      mid[ST_LATE_FIRST].d1n  <= s2_d1n;
      mid[ST_LATE_FIRST].dens <= sat_add(s2_d1s, top_depth);
      mid[ST_LATE_FIRST].denn <= sat_add(s2_d1n, top_depth);
      for (int i = ST_LATE_FIRST + 1; i <= ST_MID_LAST; i++) begin
        mid[i] <= mid[i-1];
      end

      s11_nums <= sat_add(p_s, ks_top);
      s11_numn <= sat_add(p_n, ks_top);
      s11_dens <= mid[ST_MID_LAST].dens;
      s11_denn <= mid[ST_MID_LAST].denn;

      s79_effs <= late[ST_EFF_OUT].les ? ks_w : q_s;
      s79_effn <= late[ST_EFF_OUT].len ? ks_w : q_n;
      s80_k    <= (late[ST_EFF].kind == KIND_NABR) ? mean_floor(s79_effs, s79_effn)
                                                   : s79_effs;

      qd[ST_Q_OUT+1] <= q_g;
      for (int i = ST_Q_OUT + 2; i <= ST_K; i++) begin
        qd[i] <= qd[i-1];
      end

      unique case (late[ST_E_OUT].kind)
        KIND_NABR, KIND_HEAD: out_flux <= m3;
        KIND_NOFLOW:          out_flux <= '0;
        KIND_FLUX:            out_flux <= late[ST_E_OUT].negbc;
        default:              out_flux <= '0;
      endcase
    end
  end

  // head gradient
  sdef_div u_div_grad (.clk(clk), .en(adv), .a(s2_diff), .b(word_t'(s2_dist)), .q(q_g));

  // effective conductivity of both sides
  sdef_mul u_mul_k1ds (.clk(clk), .en(adv), .a(k1), .b(mid[ST_K1D1_IN].d1s), .q(p_s));
  sdef_mul u_mul_k1dn (.clk(clk), .en(adv), .a(k1), .b(mid[ST_K1D1_IN].d1n), .q(p_n));
  sdef_div u_div_effs (.clk(clk), .en(adv), .a(s11_nums), .b(s11_dens), .q(q_s));
  sdef_div u_div_effn (.clk(clk), .en(adv), .a(s11_numn), .b(s11_denn), .q(q_n));

  // k * grad * depth * edge length
  sdef_mul u_mul_kq (.clk(clk), .en(adv), .a(s80_k), .b(qd[ST_K]), .q(m1));
  sdef_mul u_mul_h  (.clk(clk), .en(adv), .a(m1), .b(late[ST_KQ_OUT].h), .q(m2));
  sdef_mul u_mul_e  (.clk(clk), .en(adv), .a(m2), .b(word_t'(late[ST_H_OUT].edge_len)),
                     .q(m3));

  `SDEF_ASSERT_IMPL(a_stall_blocks_input, clk, rst, m_tvalid && !m_tready, !s_tready)
  `SDEF_ASSERT_NEXT(a_accept_enters, clk, rst, s_tvalid && s_tready, vld[1])
  `SDEF_ASSERT_NEXT(a_last_stage_out, clk, rst, adv && vld[ST_OUT-1], m_tvalid)

endmodule

FILE: rtl/core/sdef_mul.sv
`timescale 1ns / 1ps
module sdef_mul (
  input  logic          clk,
  input  logic          en,
  input  sdef_pkg::word_t a,
  input  sdef_pkg::word_t b,
  output sdef_pkg::word_t q
);
  import sdef_pkg::*;

  logic [WORD_W-1:0] ma, mb;
  logic              neg1, neg2, neg3;
  logic [WORD_W-1:0] pll, plh, phl, phh;
  logic [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (en) begin
      ma   <= a[WORD_W-1] ? ~a + WORD_W'(1) : a;
      mb   <= b[WORD_W-1] ? ~b + WORD_W'(1) : b;
      neg1 <= a[WORD_W-1] ^ b[WORD_W-1];
      pll  <= ma[HALF_W-1:0] * mb[HALF_W-1:0];
      plh  <= ma[HALF_W-1:0] * mb[WORD_W-1:HALF_W];
      phl  <= ma[WORD_W-1:HALF_W] * mb[HALF_W-1:0];
      phh  <= ma[WORD_W-1:HALF_W] * mb[WORD_W-1:HALF_W];
      neg2 <= neg1;
      prod <= {{WORD_W{1'b0}}, pll}
            + {{HALF_W{1'b0}}, plh, {HALF_W{1'b0}}}
            + {{HALF_W{1'b0}}, phl, {HALF_W{1'b0}}}
            + {phh, {WORD_W{1'b0}}};
      neg3 <= neg2;
      q    <= from_mag(prod[FRAC_BITS +: WORD_W], neg3, |prod[PROD_W-1:FRAC_BITS+WORD_W]);
    end
  end

endmodule

FILE: rtl/core/sdef_div.sv
`timescale 1ns / 1ps
module sdef_div (
  input  logic          clk,
  input  logic          en,
  input  sdef_pkg::word_t a,
  input  sdef_pkg::word_t b,
  output sdef_pkg::word_t q
);
  import sdef_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] rem;
    logic [WORD_W-1:0] nl;
    logic [WORD_W-1:0] quo;
    logic [WORD_W-1:0] ub;
    logic              neg;
    logic              bz;
    logic              ovf;
  } div_stage_t;

  logic [WORD_W-1:0] ua, ub;
  logic              neg0, bz0;
  div_stage_t        st [0:DIV_STEPS];
  div_stage_t        nxt [0:DIV_STEPS-1];

  always_comb begin
    logic [WORD_W:0] w;
    logic [WORD_W:0] d;
    logic            ge;
    for (int k = 0; k < DIV_STEPS; k++) begin
      w  = {st[k].rem, st[k].nl[WORD_W-1]};
      d  = w - {1'b0, st[k].ub};
      ge = (w >= {1'b0, st[k].ub});
      nxt[k]     = st[k];
      nxt[k].rem = ge ? d[WORD_W-1:0] : w[WORD_W-1:0];
      nxt[k].nl  = {st[k].nl[WORD_W-2:0], 1'b0};
      nxt[k].quo = {st[k].quo[WORD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ua   <= a[WORD_W-1] ? ~a + WORD_W'(1) : a;
      ub   <= b[WORD_W-1] ? ~b + WORD_W'(1) : b;
      neg0 <= a[WORD_W-1] ^ b[WORD_W-1];
      bz0  <= (b == '0);
      st[0].rem <= ua >> (WORD_W - FRAC_BITS);
      st[0].nl  <= ua << FRAC_BITS;
      st[0].quo <= '0;
      st[0].ub  <= ub;
      st[0].neg <= neg0;
      st[0].bz  <= bz0;
      st[0].ovf <= ((ua >> (WORD_W - FRAC_BITS)) >= ub);
      for (int k = 0; k < DIV_STEPS; k++) begin
        st[k+1] <= nxt[k];
      end
      q <= st[DIV_STEPS].bz ? word_t'(0)
         : from_mag(st[DIV_STEPS].quo, st[DIV_STEPS].neg, st[DIV_STEPS].ovf);
    end
  end

endmodule
